>>> design/lls_pkg.sv
`default_nettype none

package lls_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int BYTE_W      = 8;
    localparam int PAT_W       = PATTERN_MAX * BYTE_W;
    localparam int CFG_W       = 64;
    localparam int PAT_BANKS   = PAT_W / CFG_W;
    localparam int BANK_AW     = $clog2(PAT_BANKS);
    localparam int SHIFT_W     = $clog2(PAT_W) + 1;
    localparam int LEN_W       = 6;
    localparam int LINE_W      = 24;
    localparam int COL_W       = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [BYTE_W-1:0] BYTE_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] UTF8_CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF8_CONT_CODE = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_A  = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] ASCII_CASE_OFS = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_0_7    = 3'd0,
        CFG_PAT_8_15   = 3'd1,
        CFG_PAT_16_23  = 3'd2,
        CFG_PAT_24_31  = 3'd3,
        CFG_PAT_LEN    = 3'd4,
        CFG_CASE_SENS  = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  column;
    } t_result;

    // ASCII-only case folding; upper-case letters map to lower case.
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                     input logic case_sens);
        logic [BYTE_W-1:0] r;
        r = b;
        if (!case_sens && b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
            r = b + ASCII_CASE_OFS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/line_literal_search.sv
// Literal pattern search over a byte stream, at most one result per line.
//
// Input channel: one text byte per request with an end-of-text flag. A request
// is taken at a rising edge where i_in_valid is high and o_in_stall is low.
// Output channel: line number and UTF-8 column of the first match in a line,
// taken where o_out_valid is high and i_out_stall is low. Configuration channel:
// register index and 64-bit data, always ready. The user must write the pattern,
// its length and the case mode while the block is idle; the block does not check.
//
// Throughput is one byte per cycle while o_in_stall is low: the full 32-byte
// window compare, the character-start count and all counter updates sit
// between the state registers and the result register. A result is registered
// from the byte that completes the match; a match ending in CR is decided by
// the next byte and registered from that byte. A two-entry output buffer
// (result register plus skid register) lets bytes keep flowing while the
// receiver stalls; o_in_stall rises only once both entries hold results.
// Reset (synchronous, active low) clears the configuration, sets the line
// counter to one and empties the output buffer.
`default_nettype none

module line_literal_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_end_of_text,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lls_pkg::LINE_W-1:0]    o_line_number,
    output logic [lls_pkg::COL_W-1:0]     o_column,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lls_pkg::CFG_W-1:0]     i_cfg_data
);

    // Configuration registers. The pattern is kept flat, byte j at bits 8j+7:8j.
    logic [lls_pkg::PAT_W-1:0]  r_pat;
    logic [lls_pkg::LEN_W-1:0]  r_pat_len;
    logic                       r_case_sens;

    // Search state.
    logic [lls_pkg::PAT_W-1:0]       r_win;      // newest byte in bits 7:0
    logic [lls_pkg::PATTERN_MAX-1:0] r_cs;       // character-start flags, newest in bit 0
    logic [lls_pkg::LINE_W-1:0]      r_line;
    logic [lls_pkg::COL_W-1:0]       r_bytes;
    logic [lls_pkg::COL_W-1:0]       r_chars;
    logic                            r_reported;
    logic                            r_pending;
    logic [lls_pkg::COL_W-1:0]       r_pend_col;
    logic [lls_pkg::LINE_W-1:0]      n_line;
    logic [lls_pkg::COL_W-1:0]       n_bytes;
    logic [lls_pkg::COL_W-1:0]       n_chars;
    logic                            n_reported;
    logic                            n_pending;
    logic [lls_pkg::COL_W-1:0]       n_pend_col;

    // Output buffer.
    lls_pkg::t_result r_out;
    lls_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;
    lls_pkg::t_result n_res;
    logic             n_res_valid;

    logic                            w_in_acc;
    logic                            w_out_take;
    logic                            w_is_start;
    logic [lls_pkg::PAT_W-1:0]       w_win_sh;
    logic [lls_pkg::PATTERN_MAX-1:0] w_cs_sh;
    logic [lls_pkg::PAT_W-1:0]       w_pat_rev;
    logic [lls_pkg::PAT_W-1:0]       w_pat_sel;
    logic [lls_pkg::LEN_W-1:0]       w_shamt;
    logic [lls_pkg::PATTERN_MAX-1:0] w_mask;
    logic [lls_pkg::PATTERN_MAX-1:0] w_eq;
    logic                            w_len_ok;
    logic                            w_match;
    logic [lls_pkg::LEN_W-1:0]       w_starts;
    logic [lls_pkg::COL_W-1:0]       w_bytes_next;
    logic [lls_pkg::COL_W-1:0]       w_chars_next;
    logic [lls_pkg::COL_W-1:0]       w_col;
    logic [lls_pkg::LINE_W-1:0]      w_line_inc;

    assign o_cfg_ready   = 1'b1;
    assign o_in_stall    = r_skid_valid;
    assign o_out_valid   = r_out_valid;
    assign o_line_number = r_out.line_number;
    assign o_column      = r_out.column;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;

    // ------------------------------------------------------------------
    // Configuration writes. Indexes beyond the register list are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat       <= '0;
            r_pat_len   <= '0;
            r_case_sens <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (lls_pkg::t_cfg_index'(i_cfg_index))
                lls_pkg::CFG_PAT_0_7,
                lls_pkg::CFG_PAT_8_15,
                lls_pkg::CFG_PAT_16_23,
                lls_pkg::CFG_PAT_24_31: begin
                    r_pat[i_cfg_index[lls_pkg::BANK_AW-1:0] * lls_pkg::CFG_W +: lls_pkg::CFG_W]
                        <= i_cfg_data;
                end
                lls_pkg::CFG_PAT_LEN: begin
                    r_pat_len <= i_cfg_data[lls_pkg::LEN_W-1:0];
                end
                lls_pkg::CFG_CASE_SENS: begin
                    r_case_sens <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Window compare. Window position k (0 = newest) must match pattern byte
    // L-1-k. Reversing the pattern bytes and shifting right by 32-L bytes
    // lines each pattern byte up with its window position.
    // ------------------------------------------------------------------
    assign w_is_start = (i_text_byte & lls_pkg::UTF8_CONT_MASK) != lls_pkg::UTF8_CONT_CODE;
    assign w_win_sh   = {r_win[lls_pkg::PAT_W-lls_pkg::BYTE_W-1:0], i_text_byte};
    assign w_cs_sh    = {r_cs[lls_pkg::PATTERN_MAX-2:0], w_is_start};
    assign w_shamt    = lls_pkg::LEN_W'(lls_pkg::PATTERN_MAX) - r_pat_len;
    assign w_pat_sel  = w_pat_rev >> {w_shamt, 3'b000};
    assign w_len_ok   = (r_pat_len != '0) &&
                        (r_pat_len <= lls_pkg::LEN_W'(lls_pkg::PATTERN_MAX));

    for (genvar k = 0; k < lls_pkg::PATTERN_MAX; k++) begin : g_lane
        assign w_pat_rev[k*lls_pkg::BYTE_W +: lls_pkg::BYTE_W] =
            r_pat[(lls_pkg::PATTERN_MAX-1-k)*lls_pkg::BYTE_W +: lls_pkg::BYTE_W];
        assign w_mask[k] = lls_pkg::LEN_W'(k) < r_pat_len;
        assign w_eq[k]   = !w_mask[k] ||
            (lls_pkg::fold_byte(w_win_sh[k*lls_pkg::BYTE_W +: lls_pkg::BYTE_W], r_case_sens) ==
             lls_pkg::fold_byte(w_pat_sel[k*lls_pkg::BYTE_W +: lls_pkg::BYTE_W], r_case_sens));
    end

    assign w_bytes_next = (r_bytes != '1) ? r_bytes + 1'b1 : r_bytes;
    assign w_chars_next = (w_is_start && r_chars != '1) ? r_chars + 1'b1 : r_chars;
    assign w_starts     = lls_pkg::LEN_W'($countones(w_cs_sh & w_mask));
    assign w_match      = w_len_ok && (&w_eq) &&
                          (w_bytes_next >= lls_pkg::COL_W'(r_pat_len));
    // A saturated character count reports the saturated column.
    assign w_col        = (w_chars_next == '1) ? '1 :
                          w_chars_next - lls_pkg::COL_W'(w_starts) + 1'b1;
    assign w_line_inc   = (r_line != '1) ? r_line + 1'b1 : r_line;

    // ------------------------------------------------------------------
    // Per-byte state update and result generation.
    // ------------------------------------------------------------------
    always_comb begin
        n_line      = r_line;
        n_bytes     = r_bytes;
        n_chars     = r_chars;
        n_reported  = r_reported;
        n_pending   = r_pending;
        n_pend_col  = r_pend_col;
        n_res_valid = 1'b0;
        n_res       = '{line_number: r_line, column: w_col};
        if (w_in_acc) begin
            n_pending = 1'b0;
            // A match held on a trailing CR is released unless LF follows.
            if (r_pending && i_text_byte != lls_pkg::BYTE_LF) begin
                n_res_valid = 1'b1;
                n_res       = '{line_number: r_line, column: r_pend_col};
                n_reported  = 1'b1;
            end
            if (i_text_byte == lls_pkg::BYTE_LF) begin
                n_line     = w_line_inc;
                n_bytes    = '0;
                n_chars    = '0;
                n_reported = 1'b0;
            end else begin
                n_bytes = w_bytes_next;
                n_chars = w_chars_next;
                if (!n_reported && w_match) begin
                    if (i_text_byte == lls_pkg::BYTE_CR && !i_end_of_text) begin
                        n_pending  = 1'b1;
                        n_pend_col = w_col;
                    end else begin
                        n_res_valid = 1'b1;
                        n_res       = '{line_number: r_line, column: w_col};
                        n_reported  = 1'b1;
                    end
                end
            end
            if (i_end_of_text) begin
                n_line     = lls_pkg::LINE_W'(1);
                n_bytes    = '0;
                n_chars    = '0;
                n_reported = 1'b0;
                n_pending  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line     <= lls_pkg::LINE_W'(1);
            r_bytes    <= '0;
            r_chars    <= '0;
            r_reported <= 1'b0;
            r_pending  <= 1'b0;
        end else begin
            r_line     <= n_line;
            r_bytes    <= n_bytes;
            r_chars    <= n_chars;
            r_reported <= n_reported;
            r_pending  <= n_pending;
        end
    end

    // Window contents older than the current line are never compared, since a
    // match also needs the line's byte count to cover the pattern length.
    always_ff @(posedge i_clk) begin
        r_pend_col <= n_pend_col;
        if (w_in_acc) begin
            r_win <= w_win_sh;
            r_cs  <= w_cs_sh;
        end
    end

    // ------------------------------------------------------------------
    // Output buffer. The skid register fills only when the result register
    // is held by the receiver, and input requests stall while it is full.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= n_res_valid;
            end
        end else if (n_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_take) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end
        if (r_out_valid && !w_out_take && n_res_valid) begin
            r_skid <= n_res;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the result register is empty");

    a_pending_unreported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> !r_reported)
        else $error("held CR match in a line that already reported");

    a_result_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_line_number != '0 && o_column != '0))
        else $error("result with zero line number or column");

    a_eot_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_end_of_text) |=> (r_line == lls_pkg::LINE_W'(1) && !r_pending))
        else $error("state not restarted after end of text");

endmodule

`default_nettype wire

>>> tb/lls_match_checker.sv
module lls_match_checker
    import lls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_end_of_text,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [LINE_W-1:0]    i_line_number,
    input  logic [COL_W-1:0]     i_column,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_open,
    output int                   o_checked
);

    localparam logic [LINE_W-1:0] LINE_LIMIT  = '1;
    localparam int                COUNT_LIMIT = 65535;

    // Search settings as last written.
    logic [CFG_W-1:0] pat_bank [PAT_BANKS];
    logic [LEN_W-1:0] pat_len;
    logic             exact_case;

    // Line state of the search, newest text byte at index 0.
    logic [7:0]             hist_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hist_start;
    logic [LINE_W-1:0]      cur_line;
    int                     line_bytes;
    int                     line_chars;
    logic                   line_done;
    logic                   cr_hold;
    logic [COL_W-1:0]       cr_col;

    t_result match_q [$];
    int      errors  = 0;
    int      checked = 0;

    // Appends one predicted result behind those still awaited.
    function automatic void expect_result(input t_result r);
        match_q.insert(match_q.size(), r);
    endfunction

    function automatic logic [7:0] lower_if_folding(input logic [7:0] b);
        if (!exact_case && b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
            return b + ASCII_CASE_OFS;
        end
        return b;
    endfunction

    function automatic logic [7:0] pattern_byte(input int j);
        return pat_bank[j / 8][(j % 8) * 8 +: 8];
    endfunction

    // True when the pattern ends at the newest byte; col is its start column.
    function automatic logic ends_here(output logic [COL_W-1:0] col);
        int len;
        int starts;
        int j;
        len    = pat_len;
        starts = 0;
        col    = '0;
        if (len == 0 || len > PATTERN_MAX || line_bytes < len) begin
            return 1'b0;
        end
        for (j = 0; j < len; j++) begin
            if (lower_if_folding(hist_byte[len-1-j]) != lower_if_folding(pattern_byte(j))) begin
                return 1'b0;
            end
            starts += hist_start[len-1-j];
        end
        if (line_chars >= COUNT_LIMIT) begin
            col = COL_W'(COUNT_LIMIT);
        end else begin
            col = COL_W'(line_chars - starts + 1);
        end
        return 1'b1;
    endfunction

    function automatic void clear_line();
        int i;
        for (i = 0; i < PATTERN_MAX; i++) begin
            hist_byte[i] = '0;
        end
        hist_start = '0;
        line_bytes = 0;
        line_chars = 0;
        line_done  = 1'b0;
        cr_hold    = 1'b0;
        cr_col     = '0;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic eot);
        logic [COL_W-1:0] col;
        logic             is_start;
        int               i;
        if (cr_hold) begin
            if (b != BYTE_LF) begin
                expect_result(t_result'{line_number: cur_line, column: cr_col});
                line_done = 1'b1;
            end
            cr_hold = 1'b0;
        end
        if (b == BYTE_LF) begin
            clear_line();
            if (cur_line != LINE_LIMIT) begin
                cur_line = cur_line + 1'b1;
            end
        end else begin
            is_start = (b & UTF8_CONT_MASK) != UTF8_CONT_CODE;
            for (i = PATTERN_MAX - 1; i > 0; i--) begin
                hist_byte[i] = hist_byte[i-1];
            end
            hist_byte[0] = b;
            hist_start   = {hist_start[PATTERN_MAX-2:0], is_start};
            if (line_bytes < COUNT_LIMIT) begin
                line_bytes++;
            end
            if (is_start && line_chars < COUNT_LIMIT) begin
                line_chars++;
            end
            if (!line_done && ends_here(col)) begin
                if (b == BYTE_CR && !eot) begin
                    cr_hold = 1'b1;
                    cr_col  = col;
                end else begin
                    expect_result(t_result'{line_number: cur_line, column: col});
                    line_done = 1'b1;
                end
            end
        end
        if (eot) begin
            clear_line();
            cur_line = 1;
        end
    endtask

    task automatic flag(input string what);
        errors++;
        if (errors <= 10) begin
            $display("lls_match_checker: %s", what);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        int      b;
        if (!i_rst_n) begin
            for (b = 0; b < PAT_BANKS; b++) begin
                pat_bank[b] = '0;
            end
            pat_len    = '0;
            exact_case = 1'b0;
            clear_line();
            cur_line = 1;
            match_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (match_q.size() == 0) begin
                    flag($sformatf("unexpected result line %0d column %0d",
                                   i_line_number, i_column));
                end else begin
                    want = match_q.pop_front();
                    checked++;
                    if (i_line_number !== want.line_number) begin
                        flag($sformatf("line number: expected %0d, got %0d",
                                       want.line_number, i_line_number));
                    end
                    if (i_column !== want.column) begin
                        flag($sformatf("column on line %0d: expected %0d, got %0d",
                                       want.line_number, want.column, i_column));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_PAT_0_7:   pat_bank[0] = i_cfg_data;
                    CFG_PAT_8_15:  pat_bank[1] = i_cfg_data;
                    CFG_PAT_16_23: pat_bank[2] = i_cfg_data;
                    CFG_PAT_24_31: pat_bank[3] = i_cfg_data;
                    CFG_PAT_LEN:   pat_len = i_cfg_data[LEN_W-1:0];
                    CFG_CASE_SENS: exact_case = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                take_byte(i_text_byte, i_end_of_text);
            end
        end
        o_errors  <= errors;
        o_open    <= match_q.size();
        o_checked <= checked;
    end

endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the line search block. The checker instance beside
// the block watches all three channels, predicts every match and compares it;
// this module only drives requests, idles both sides and reports the outcome.
module tb_top;
    import lls_pkg::*;

    // Random text bytes to send once the directed part is done.
    localparam int TEXT_ITEMS = 1300;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [7:0]           text_byte    = '0;
    logic                 end_of_text  = 1'b0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [LINE_W-1:0]    line_number;
    logic [COL_W-1:0]     column;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    int mismatches;
    int open_matches;
    int matches_checked;

    // When quiet is set neither side idles, so whole phases run back to back.
    bit quiet          = 1'b0;
    int stall_left     = 0;
    int stall_pick;
    int bytes_sent     = 0;
    int settings_used  = 0;

    // The current search settings, kept so the text generator can plant the
    // pattern into lines.
    logic [PAT_W-1:0] pattern     = '0;
    logic [LEN_W-1:0] pattern_len = '0;
    logic             exact       = 1'b0;

    line_literal_search dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_text_byte   (text_byte),
        .i_end_of_text (end_of_text),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_line_number (line_number),
        .o_column      (column),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    lls_match_checker u_watch (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_text_byte   (text_byte),
        .i_end_of_text (end_of_text),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_line_number (line_number),
        .i_column      (column),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_errors      (mismatches),
        .o_open        (open_matches),
        .o_checked     (matches_checked)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Hard stop. The slowest legal run, with every byte taking the longest
    // sender gap and every result the longest receiver stall, stays well
    // under a fifth of this.
    initial begin
        #4000000;
        $display("tb_top: errors");
        $finish;
    end

    // Receiver back-pressure. Each decision holds the stall level for a
    // short run of cycles, and now and then for a long one, so that the
    // output buffer fills and the input side sees its stall too.
    always @(posedge clk) begin
        if (quiet) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            out_stall  <= (stall_pick < 35);
            stall_left <= (stall_pick < 5) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        end
    end

    // Sender gap after a request: mostly none, sometimes a few cycles, rarely
    // a long pause.
    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // One text request. The payload is held until the block takes it; valid
    // only drops when a gap follows, so back-to-back requests never lower and
    // raise it within one time step.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        text_byte   <= b;
        end_of_text <= eot;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Settings change only while the block is idle: every predicted match
    // has been received, and a few more cycles let anything still in the
    // output pipeline drain.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (open_matches != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input t_cfg_index idx, input logic [CFG_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Writes all six registers in one burst, valid staying high throughout.
    task automatic set_search(input logic [PAT_W-1:0] p, input logic [LEN_W-1:0] len,
                              input logic ex);
        pattern     = p;
        pattern_len = len;
        exact       = ex;
        put_reg(CFG_PAT_0_7, p[63:0]);
        put_reg(CFG_PAT_8_15, p[127:64]);
        put_reg(CFG_PAT_16_23, p[191:128]);
        put_reg(CFG_PAT_24_31, p[255:192]);
        put_reg(CFG_PAT_LEN, CFG_W'(len));
        put_reg(CFG_CASE_SENS, CFG_W'(ex));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // A small alphabet keeps partial and full matches frequent: letters in
    // both cases, CR, a two-byte UTF-8 character, a stray continuation byte
    // and the odd fully random byte.
    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(0, 9))
            0: return "a";
            1: return "A";
            2: return "b";
            3: return "B";
            4: return BYTE_CR;
            5: return 8'hC3;
            6: return 8'hA9;
            7: return UTF8_CONT_CODE;
            8: return "z";
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] swap_case(input logic [7:0] b);
        if ((b | ASCII_CASE_OFS) >= "a" && (b | ASCII_CASE_OFS) <= "z") begin
            return b ^ ASCII_CASE_OFS;
        end
        return b;
    endfunction

    // A new search setting for one random phase. The first phases force the
    // extremes of the length: full width, one byte, empty and overlong. The
    // register bytes past the length are junk that must be ignored.
    task automatic pick_setting(input int phase);
        logic [PAT_W-1:0] p;
        int               len;
        int               k;
        case (phase)
            0: len = PATTERN_MAX;
            1: len = 1;
            2: len = 0;
            3: len = $urandom_range(PATTERN_MAX + 1, 63);
            default: begin
                if ($urandom_range(0, 9) < 8) begin
                    len = $urandom_range(1, 6);
                end else begin
                    len = $urandom_range(0, 63);
                end
            end
        endcase
        for (k = 0; k < PATTERN_MAX; k++) begin
            p[k*8 +: 8] = (k < len) ? pick_symbol() : 8'($urandom());
        end
        set_search(p, LEN_W'(len), 1'($urandom_range(0, 1)));
    endtask

    // One line of text. Most lines carry the pattern between random filler,
    // with letter case flipped freely when folding is on and rarely when it
    // is off. Line ends vary between LF, CR LF, end of text on LF or CR, and
    // no end at all. A share of lines is plain noise instead.
    task automatic send_line();
        int          len;
        int          r;
        int          k;
        logic [7:0]  b;
        len = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : pattern_len;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(0, 12)) begin
                send_byte(8'($urandom()), $urandom_range(0, 99) == 0);
            end
        end else begin
            repeat ($urandom_range(0, 6)) send_byte(pick_symbol(), 1'b0);
            if ($urandom_range(0, 99) < 75) begin
                for (k = 0; k < len; k++) begin
                    b = pattern[k*8 +: 8];
                    if ($urandom_range(0, 99) < (exact ? 5 : 50)) begin
                        b = swap_case(b);
                    end
                    send_byte(b, 1'b0);
                end
            end
            repeat ($urandom_range(0, 4)) send_byte(pick_symbol(), 1'b0);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_byte(BYTE_LF, 1'b0);
            end else if (r < 75) begin
                send_byte(BYTE_CR, 1'b0);
                send_byte(BYTE_LF, 1'b0);
            end else if (r < 85) begin
                send_byte(BYTE_LF, 1'b1);
            end else if (r < 92) begin
                send_byte(BYTE_CR, 1'b1);
            end
        end
    endtask

    initial begin
        int phase;
        int first_random;
        int phase_start;
        int phase_len;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Straight after reset the pattern is empty and nothing may match.
        send_byte("a", 1'b0);
        send_byte(8'h00, 1'b0);

        // Pattern "b" CR, folded. A match ending in CR is dropped when LF
        // follows, reported on the next byte otherwise, and reported at once
        // when the CR is the last byte of the text.
        wait_idle();
        set_search({{30{8'h00}}, BYTE_CR, 8'h62}, 6'd2, 1'b0);
        send_byte("B", 1'b0);
        send_byte(BYTE_CR, 1'b0);
        send_byte(BYTE_LF, 1'b0);
        send_byte("b", 1'b0);
        send_byte(BYTE_CR, 1'b0);
        send_byte("x", 1'b0);
        send_byte(BYTE_LF, 1'b0);
        send_byte("b", 1'b0);
        send_byte(BYTE_CR, 1'b1);

        // Exact compare on extreme byte values and UTF-8. The wrong-case
        // letter spoils the first line; on the second a three-byte character
        // ahead of the match counts as one column.
        wait_idle();
        set_search({{28{8'h00}}, 8'h5A, 8'hA9, 8'hC3, 8'hFF}, 6'd4, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte("z", 1'b0);
        send_byte(BYTE_LF, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte("Z", 1'b1);

        // A length beyond the pattern store never matches.
        wait_idle();
        set_search({32{8'h61}}, 6'd33, 1'b0);
        send_byte("A", 1'b0);
        send_byte("a", 1'b0);
        send_byte(BYTE_LF, 1'b0);

        // Random phases, each under a fresh setting; every fourth runs with
        // no idling on either side.
        first_random = bytes_sent;
        phase        = 0;
        while (bytes_sent - first_random < TEXT_ITEMS) begin
            wait_idle();
            quiet <= (phase % 4 == 3);
            pick_setting(phase);
            phase_len   = $urandom_range(60, 160);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < phase_len) begin
                send_line();
            end
            phase++;
        end

        wait_idle();
        $display("tb_top: %0d text bytes sent under %0d search settings", bytes_sent,
                 settings_used);
        $display("tb_top: %0d line matches compared", matches_checked);
        if (mismatches == 0 && open_matches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/lls_pkg.sv
design/line_literal_search.sv
tb/lls_match_checker.sv
tb/tb_top.sv
